// File: design/rvspg_pkg.sv
// shared types, constants and palettes for the scanline pixel generator
package rvspg_pkg;

    localparam int unsigned TEXT_ROW_STRIDE_DEF     = 128;
    localparam int unsigned TEXT_SEGMENT_STRIDE_DEF = 40;
    localparam int unsigned MIXED_SPLIT_LINE_DEF    = 160;

    localparam logic [7:0]  FRAME_LINES        = 8'd192;
    localparam logic [15:0] TEXT_PAGE_BASE     = 16'h0400;
    localparam logic [15:0] HIRES_PAGE_BASE    = 16'h2000;
    localparam logic [15:0] HIRES_LINE_STRIDE  = 16'h0400;
    localparam logic [15:0] HIRES_ROW_STRIDE   = 16'h0080;
    localparam logic [15:0] HIRES_SEG_STRIDE   = 16'h0028;

    // soft switch bus addresses
    localparam logic [15:0] ADDR_TEXT_CLR   = 16'hC050;
    localparam logic [15:0] ADDR_TEXT_SET   = 16'hC051;
    localparam logic [15:0] ADDR_MIXED_CLR  = 16'hC052;
    localparam logic [15:0] ADDR_MIXED_SET  = 16'hC053;
    localparam logic [15:0] ADDR_PAGE2_CLR  = 16'hC054;
    localparam logic [15:0] ADDR_PAGE2_SET  = 16'hC055;
    localparam logic [15:0] ADDR_HIRES_CLR  = 16'hC056;
    localparam logic [15:0] ADDR_HIRES_SET  = 16'hC057;
    localparam logic [15:0] ADDR_DHIRES_SET = 16'hC05E;
    localparam logic [15:0] ADDR_DHIRES_CLR = 16'hC05F;

    // bit positions in the soft switch register
    localparam int unsigned SW_TEXT   = 0;
    localparam int unsigned SW_MIXED  = 1;
    localparam int unsigned SW_HIRES  = 2;
    localparam int unsigned SW_PAGE2  = 3;
    localparam int unsigned SW_DHIRES = 4;
    localparam int unsigned SW_BITS   = 5;

    localparam logic [3:0] PAL_BLACK = 4'd0;
    localparam logic [3:0] PAL_WHITE = 4'd9;

    typedef enum logic {
        OP_BUS    = 1'b0,
        OP_RENDER = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] bus_address;
        logic [7:0]  line;
        logic [5:0]  column;
        logic [7:0]  text_page_byte;
        logic [7:0]  hires_prev;
        logic [7:0]  hires_cur;
        logic [7:0]  hires_next;
        logic [6:0]  glyph_row;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel0;
        logic [15:0] pixel1;
        logic [15:0] pixel2;
        logic [15:0] pixel3;
        logic [15:0] pixel4;
        logic [15:0] pixel5;
        logic [15:0] pixel6;
        logic [15:0] text_line_base;
        logic [15:0] hires_line_base;
    } t_out_item;

    function automatic logic [15:0] hires_color(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd1, 4'd4: c = 16'hD91B;
            4'd2, 4'd3: c = 16'h16E0;
            4'd5, 4'd8: c = 16'h211F;
            4'd6, 4'd7: c = 16'hFB20;
            4'd9:       c = 16'hFFFF;
            default:    c = 16'h0000;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] lores_color(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'hD806;
            4'd2:    c = 16'h0013;
            4'd3:    c = 16'hD91B;
            4'd4:    c = 16'h03A4;
            4'd5:    c = 16'h52AA;
            4'd6:    c = 16'h211F;
            4'd7:    c = 16'h655F;
            4'd8:    c = 16'h8AA0;
            4'd9:    c = 16'hFB20;
            4'd10:   c = 16'hAD55;
            4'd11:   c = 16'hFCD1;
            4'd12:   c = 16'h16E0;
            4'd13:   c = 16'hFFE0;
            4'd14:   c = 16'h47F3;
            default: c = 16'hFFFF;
        endcase
        return c;
    endfunction

endpackage

// File: design/retro_video_scanline_pixel_generator.sv
// top level: soft switches and one-byte scanline renderer
// Takes one transaction per clock unless stalled. A bus access (op 0) updates the video soft
// switches and returns nothing; a render (op 1) of a visible line returns seven RGB565 pixels
// plus the text and hi-res line base addresses. Each transaction passes an input register,
// one level of palette and address logic, then the result register, and the block sustains
// one transaction per cycle while the result side drains. Input stall rises only when both
// registers hold data and the result side is stalled.
module retro_video_scanline_pixel_generator #(
    parameter int unsigned TEXT_ROW_STRIDE     = rvspg_pkg::TEXT_ROW_STRIDE_DEF,
    parameter int unsigned TEXT_SEGMENT_STRIDE = rvspg_pkg::TEXT_SEGMENT_STRIDE_DEF,
    parameter int unsigned MIXED_SPLIT_LINE    = rvspg_pkg::MIXED_SPLIT_LINE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rvspg_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rvspg_pkg::t_out_item o_out_data
);

    localparam logic [8:0] SPLIT_LINE = 9'(MIXED_SPLIT_LINE);

    logic                                 r_s1_valid;
    rvspg_pkg::t_in_item                  r_s1_data;
    logic                                 r_out_valid;
    rvspg_pkg::t_out_item                 r_out_data;
    logic [rvspg_pkg::SW_BITS-1:0]        r_sw;
    logic [rvspg_pkg::SW_BITS-1:0]        n_sw;
    rvspg_pkg::t_out_item                 n_out_data;
    logic                                 n_out_valid;
    logic                                 s1_adv;
    logic                                 in_accept;
    logic                                 text_mode;
    logic [10:0]                          ext;
    logic [3:0]                           base;
    logic [3:0]                           idx;
    logic                                 on_bit;
    logic                                 lft;
    logic                                 rgt;
    logic                                 odd_bit;
    logic [15:0]                          px [7];
    logic [15:0]                          lo_color;
    logic [31:0]                          t_sum;
    logic [15:0]                          h_sum;
    logic [7:0]                           y;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // soft switch update for bus accesses
    always_comb begin
        n_sw = r_sw;
        if (r_s1_data.op == rvspg_pkg::OP_BUS) begin
            case (r_s1_data.bus_address)
                rvspg_pkg::ADDR_TEXT_CLR:   n_sw[rvspg_pkg::SW_TEXT]   = 1'b0;
                rvspg_pkg::ADDR_TEXT_SET:   n_sw[rvspg_pkg::SW_TEXT]   = 1'b1;
                rvspg_pkg::ADDR_MIXED_CLR:  n_sw[rvspg_pkg::SW_MIXED]  = 1'b0;
                rvspg_pkg::ADDR_MIXED_SET:  n_sw[rvspg_pkg::SW_MIXED]  = 1'b1;
                rvspg_pkg::ADDR_PAGE2_CLR:  n_sw[rvspg_pkg::SW_PAGE2]  = 1'b0;
                rvspg_pkg::ADDR_PAGE2_SET:  n_sw[rvspg_pkg::SW_PAGE2]  = 1'b1;
                rvspg_pkg::ADDR_HIRES_CLR:  n_sw[rvspg_pkg::SW_HIRES]  = 1'b0;
                rvspg_pkg::ADDR_HIRES_SET:  n_sw[rvspg_pkg::SW_HIRES]  = 1'b1;
                rvspg_pkg::ADDR_DHIRES_SET: n_sw[rvspg_pkg::SW_DHIRES] = 1'b1;
                rvspg_pkg::ADDR_DHIRES_CLR: n_sw[rvspg_pkg::SW_DHIRES] = 1'b0;
                default: ;
            endcase
        end
    end

    // render path
    always_comb begin
        y         = r_s1_data.line;
        text_mode = r_sw[rvspg_pkg::SW_TEXT] ||
                    (r_sw[rvspg_pkg::SW_MIXED] && ({1'b0, y} >= SPLIT_LINE));
        ext       = {r_s1_data.hires_next[1:0], r_s1_data.hires_cur[6:0],
                     r_s1_data.hires_prev[6:5]};
        base      = {1'b0, r_s1_data.hires_cur[7], r_s1_data.column[0], 1'b0};
        lo_color  = rvspg_pkg::lores_color(r_s1_data.text_page_byte[7:4]);
        on_bit    = 1'b0;
        lft       = 1'b0;
        rgt       = 1'b0;
        odd_bit   = 1'b0;
        idx       = rvspg_pkg::PAL_BLACK;
        for (int i = 0; i < 7; i++) begin
            on_bit  = ext[i+2];
            lft     = ext[i+1];
            rgt     = ext[i+3];
            odd_bit = ((i % 2) == 1);
            if (on_bit) begin
                idx = (lft || rgt) ? rvspg_pkg::PAL_WHITE : base + {3'b0, odd_bit} + 4'd1;
            end else if (lft && rgt) begin
                idx = base + 4'd2 - {3'b0, odd_bit};
            end else begin
                idx = rvspg_pkg::PAL_BLACK;
            end
            if (text_mode) begin
                px[i] = rvspg_pkg::hires_color(r_s1_data.glyph_row[i] ? rvspg_pkg::PAL_BLACK
                                                                      : rvspg_pkg::PAL_WHITE);
            end else if (r_sw[rvspg_pkg::SW_HIRES]) begin
                px[i] = rvspg_pkg::hires_color(idx);
            end else begin
                px[i] = lo_color;
            end
        end

        t_sum = 32'(rvspg_pkg::TEXT_PAGE_BASE)
              + (r_sw[rvspg_pkg::SW_PAGE2] ? 32'(rvspg_pkg::TEXT_PAGE_BASE) : 32'd0)
              + 32'(y[5:3]) * TEXT_ROW_STRIDE
              + 32'(y[7:6]) * TEXT_SEGMENT_STRIDE;
        h_sum = rvspg_pkg::HIRES_PAGE_BASE
              + (r_sw[rvspg_pkg::SW_PAGE2] ? rvspg_pkg::HIRES_PAGE_BASE : 16'd0)
              + 16'(y[2:0]) * rvspg_pkg::HIRES_LINE_STRIDE
              + 16'(y[5:3]) * rvspg_pkg::HIRES_ROW_STRIDE
              + 16'(y[7:6]) * rvspg_pkg::HIRES_SEG_STRIDE;

        n_out_data.pixel0          = px[0];
        n_out_data.pixel1          = px[1];
        n_out_data.pixel2          = px[2];
        n_out_data.pixel3          = px[3];
        n_out_data.pixel4          = px[4];
        n_out_data.pixel5          = px[5];
        n_out_data.pixel6          = px[6];
        n_out_data.text_line_base  = t_sum[15:0];
        n_out_data.hires_line_base = h_sum;

        // lines past the frame give no transaction
        n_out_valid = (r_s1_data.op == rvspg_pkg::OP_RENDER) && (y < rvspg_pkg::FRAME_LINES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sw        <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= n_out_valid;
                r_sw        <= n_sw;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_in_data;
        end
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: design/rvspg_checker.sv
// port-level checks for the scanline pixel generator, bound to the top level
module rvspg_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input rvspg_pkg::t_out_item o_out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result transaction dropped or changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input side backs up only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result side can move");

    // hi-res base is 8-byte aligned and lies inside page 1 or page 2
    a_hires_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hires_line_base[2:0] == 3'b000 &&
                         (o_out_data.hires_line_base[15:13] == 3'b001 ||
                          o_out_data.hires_line_base[15:13] == 3'b010)))
        else $error("hi-res line base out of range");

endmodule

bind retro_video_scanline_pixel_generator rvspg_checker u_rvspg_checker (.*);
